[design/pl0rsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl0rsm_pkg
// Shared constants, opcodes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pl0rsm_pkg;

    localparam int CODE_DEPTH      = 512;
    localparam int CODE_AW         = $clog2(CODE_DEPTH);
    localparam int REG_COUNT       = 8;
    localparam int REG_AW          = $clog2(REG_COUNT);
    localparam int DEF_STACK_DEPTH = 32;
    localparam int WORD_W          = 32;
    localparam int ADDR_W          = 34;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_DIVZ  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // Opcodes
    localparam logic [4:0] OP_LIT = 5'd1;
    localparam logic [4:0] OP_RTN = 5'd2;
    localparam logic [4:0] OP_LOD = 5'd3;
    localparam logic [4:0] OP_STO = 5'd4;
    localparam logic [4:0] OP_CAL = 5'd5;
    localparam logic [4:0] OP_INC = 5'd6;
    localparam logic [4:0] OP_JMP = 5'd7;
    localparam logic [4:0] OP_JPC = 5'd8;
    localparam logic [4:0] OP_WRT = 5'd9;
    localparam logic [4:0] OP_RED = 5'd10;
    localparam logic [4:0] OP_HLT = 5'd11;
    localparam logic [4:0] OP_NEG = 5'd12;
    localparam logic [4:0] OP_ADD = 5'd13;
    localparam logic [4:0] OP_SUB = 5'd14;
    localparam logic [4:0] OP_MUL = 5'd15;
    localparam logic [4:0] OP_DIV = 5'd16;
    localparam logic [4:0] OP_ODD = 5'd17;
    localparam logic [4:0] OP_MOD = 5'd18;
    localparam logic [4:0] OP_EQL = 5'd19;
    localparam logic [4:0] OP_NEQ = 5'd20;
    localparam logic [4:0] OP_LSS = 5'd21;
    localparam logic [4:0] OP_LEQ = 5'd22;
    localparam logic [4:0] OP_GTR = 5'd23;
    localparam logic [4:0] OP_GEQ = 5'd24;

    typedef enum logic [4:0] {
        ACT_CLEAR, ACT_IDLE, ACT_RD_A, ACT_RD_B, ACT_RD_R, ACT_CAP_R, ACT_EXEC,
        ACT_WALK_INIT, ACT_WALK_STEP, ACT_WALK_CAP, ACT_MEM, ACT_MEM_DONE,
        ACT_CAL_WR, ACT_RTN0, ACT_RTN1, ACT_RTN2, ACT_DIV_START, ACT_DIV_STEP,
        ACT_DIV_DONE, ACT_OUT
    } act_t;

    typedef struct packed {
        act_t act;
        logic load;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [4:0] op;
        logic       halt;
        logic       clear_done;
        logic       cal_ovf;
        logic       walk_idle;
        logic       walk_bad;
        logic       mem_ok;
        logic       div_zero;
        logic       div_last;
        logic       cal_last;
    } stat_t;

endpackage

[design/pl0rsm_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl0rsm_datapath
// Register file, data stack, machine pointers, divider and result registers.
// ----------------------------------------------------------------------------
module pl0rsm_datapath
    import pl0rsm_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cmd_t                      cmd,
    output stat_t                     st,
    input  logic [4:0]                in_opcode,
    input  logic [2:0]                in_reg_r,
    input  logic [2:0]                in_level_l,
    input  logic signed [15:0]        in_operand_m,
    input  logic signed [WORD_W-1:0]  in_console_in,
    output logic [CODE_AW-1:0]        o_next_pc,
    output logic                      o_halted,
    output logic [1:0]                o_status,
    output logic                      o_print_valid,
    output logic signed [WORD_W-1:0]  o_print_value,
    output logic                      o_input_taken
);

    localparam int SW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1) + 1;
    localparam logic [ADDR_W-1:0] DEPTH_A = ADDR_W'(STACK_DEPTH);

    function automatic logic in_stk(input logic [ADDR_W-1:0] x);
        return !x[ADDR_W-1] && (x < DEPTH_A);
    endfunction

    function automatic logic [ADDR_W-1:0] sx_p(input logic [PW-1:0] p);
        return {{(ADDR_W-PW){p[PW-1]}}, p};
    endfunction

    // Storage
    logic [WORD_W-1:0] rf_mem [REG_COUNT];
    logic [WORD_W-1:0] stk_mem [STACK_DEPTH];
    logic [WORD_W-1:0] rf_q, stk_q;

    // Instruction latches
    logic [4:0]        op_reg;
    logic [2:0]        r_reg, l_reg;
    logic [15:0]       m_reg;
    logic [WORD_W-1:0] con_reg;
    logic [WORD_W-1:0] a_reg, b_reg, rr_reg, nb_reg;

    // Machine state
    logic [CODE_AW-1:0] pc_reg, npc_reg, npc_next;
    logic [PW-1:0]      bp_reg, sp_reg, gp_reg, bp_next, sp_next, gp_next;
    logic               halt_reg, halt_next;
    logic [1:0]         stat_reg, stat_next;
    logic               pv_reg, pv_next, tk_reg, tk_next;
    logic [WORD_W-1:0]  pval_reg, pval_next;

    // Link walk and call sequencing
    logic [ADDR_W-1:0] wb_reg, wb_next;
    logic [2:0]        wcnt_reg, wcnt_next;
    logic              wok_reg, wok_next;
    logic [1:0]        ccnt_reg;
    logic [SW-1:0]     clr_reg;

    // Divider
    logic [WORD_W-1:0] dvs_reg, quo_reg, quo_next;
    logic [WORD_W:0]   rem_reg, rem_next, rem_sh;
    logic [4:0]        dcnt_reg;
    logic              qneg_reg, rneg_reg;

    // Memory port controls
    logic              rf_we, stk_we;
    logic [REG_AW-1:0] rf_wa, rf_ra;
    logic [WORD_W-1:0] rf_wd, stk_wd;
    logic [SW-1:0]     stk_wa, stk_ra;

    logic [ADDR_W-1:0] m34, sp34, gp34, bp34, walk_prev, mem_addr, inc_s, inc_g, cal_a;
    logic [ADDR_W-1:0] rtn_a0, rtn_a1;
    logic              ovf_cal, ovf_inc;
    logic [CODE_AW-1:0] target;
    logic [WORD_W-1:0]  prod;
    logic signed [WORD_W-1:0] sa, sb;

    assign m34       = {{(ADDR_W-16){m_reg[15]}}, m_reg};
    assign sp34      = sx_p(sp_reg);
    assign gp34      = sx_p(gp_reg);
    assign bp34      = sx_p(bp_reg);
    assign walk_prev = wb_reg - ADDR_W'(1);
    assign mem_addr  = (wb_reg == '0) ? m34 : wb_reg - m34;
    assign inc_s     = sp34 - m34;
    assign inc_g     = gp34 + m34;
    assign ovf_cal   = $signed(sp34 - ADDR_W'(4)) <= $signed(gp34);
    assign ovf_inc   = $signed(inc_s) <= $signed(gp34);
    assign cal_a     = sp34 - ADDR_W'(ccnt_reg) - ADDR_W'(1);
    assign rtn_a0    = bp34 - ADDR_W'(2);
    assign rtn_a1    = bp34 - ADDR_W'(3);
    assign target    = m_reg[CODE_AW-1:0];
    assign prod      = a_reg * b_reg;
    assign sa        = a_reg;
    assign sb        = b_reg;
    assign rem_sh    = {rem_reg[WORD_W-1:0], quo_reg[WORD_W-1]};

    // Status towards the controller
    always_comb begin
        st.op         = op_reg;
        st.halt       = halt_reg;
        st.clear_done = (clr_reg == SW'(STACK_DEPTH - 1));
        st.cal_ovf    = ovf_cal;
        st.walk_idle  = (wcnt_reg == 3'd0);
        st.walk_bad   = !in_stk(walk_prev);
        st.mem_ok     = wok_reg && in_stk(mem_addr);
        st.div_zero   = (b_reg == '0);
        st.div_last   = (dcnt_reg == 5'd0);
        st.cal_last   = (ccnt_reg == 2'd3);
    end

    // Work out this cycle's writes and next values
    always_comb begin
        rf_we = 1'b0; rf_wa = r_reg; rf_wd = '0; rf_ra = l_reg;
        stk_we = 1'b0; stk_wa = clr_reg; stk_wd = '0; stk_ra = '0;
        npc_next = npc_reg; bp_next = bp_reg; sp_next = sp_reg; gp_next = gp_reg;
        halt_next = halt_reg; stat_next = stat_reg;
        pv_next = pv_reg; pval_next = pval_reg; tk_next = tk_reg;
        wb_next = wb_reg; wcnt_next = wcnt_reg; wok_next = wok_reg;
        rem_next = rem_reg; quo_next = quo_reg;
        unique case (cmd.act)
            ACT_CLEAR: begin
                stk_we = 1'b1;
                rf_we  = ({1'b0, clr_reg} < (SW+1)'(REG_COUNT));
                rf_wa  = clr_reg[REG_AW-1:0];
            end
            ACT_IDLE: begin
                npc_next  = halt_reg ? pc_reg : pc_reg + CODE_AW'(1);
                stat_next = ST_OK;
                pv_next = 1'b0; pval_next = '0; tk_next = 1'b0;
            end
            ACT_RD_A: rf_ra = l_reg;
            ACT_RD_B: rf_ra = m_reg[REG_AW-1:0];
            ACT_RD_R: rf_ra = r_reg;
            ACT_CAP_R: ;
            ACT_EXEC: begin
                rf_we = 1'b1;
                case (op_reg)
                    OP_LIT: rf_wd = {{(WORD_W-16){m_reg[15]}}, m_reg};
                    OP_NEG: rf_wd = '0 - a_reg;
                    OP_ADD: rf_wd = a_reg + b_reg;
                    OP_SUB: rf_wd = a_reg - b_reg;
                    OP_MUL: rf_wd = prod;
                    OP_ODD: rf_wd = {{(WORD_W-1){1'b0}}, rr_reg[0]};
                    OP_EQL: rf_wd = WORD_W'(sa == sb);
                    OP_NEQ: rf_wd = WORD_W'(sa != sb);
                    OP_LSS: rf_wd = WORD_W'(sa < sb);
                    OP_LEQ: rf_wd = WORD_W'(sa <= sb);
                    OP_GTR: rf_wd = WORD_W'(sa > sb);
                    OP_GEQ: rf_wd = WORD_W'(sa >= sb);
                    OP_RED: begin
                        rf_wd = con_reg; tk_next = 1'b1;
                    end
                    default: rf_we = 1'b0;
                endcase
                case (op_reg)
                    OP_JMP: npc_next = target;
                    OP_JPC: if (rr_reg == '0) npc_next = target;
                    OP_WRT: begin
                        pv_next = 1'b1; pval_next = rr_reg;
                    end
                    OP_HLT: halt_next = 1'b1;
                    OP_CAL: if (ovf_cal) begin
                        halt_next = 1'b1; stat_next = ST_OVF;
                    end
                    OP_INC: begin
                        if (ovf_inc) begin
                            halt_next = 1'b1; stat_next = ST_OVF;
                        end else if (bp_reg == '0) begin
                            gp_next = ($signed(inc_g) < -34'sd1) ? '1 : inc_g[PW-1:0];
                        end else begin
                            sp_next = ($signed(inc_s) > $signed(DEPTH_A)) ?
                                      PW'(STACK_DEPTH) : inc_s[PW-1:0];
                        end
                    end
                    default: ;
                endcase
            end
            ACT_WALK_INIT: begin
                wb_next = bp34; wcnt_next = l_reg; wok_next = 1'b1;
            end
            ACT_WALK_STEP: begin
                stk_ra = walk_prev[SW-1:0];
                if (wcnt_reg != 3'd0 && !in_stk(walk_prev)) begin
                    wok_next = 1'b0; wb_next = '0; wcnt_next = 3'd0;
                end
            end
            ACT_WALK_CAP: begin
                wb_next   = {{(ADDR_W-WORD_W){stk_q[WORD_W-1]}}, stk_q};
                wcnt_next = wcnt_reg - 3'd1;
            end
            ACT_MEM: begin
                stk_ra = mem_addr[SW-1:0];
                if (!(wok_reg && in_stk(mem_addr))) begin
                    stat_next = ST_RANGE;
                    rf_we = (op_reg == OP_LOD);
                end else if (op_reg == OP_STO) begin
                    stk_we = 1'b1; stk_wa = mem_addr[SW-1:0]; stk_wd = rr_reg;
                end
            end
            ACT_MEM_DONE: begin
                rf_we = 1'b1; rf_wd = stk_q;
            end
            ACT_CAL_WR: begin
                stk_we = 1'b1; stk_wa = cal_a[SW-1:0];
                case (ccnt_reg)
                    2'd0: stk_wd = '0;
                    2'd1: stk_wd = wb_reg[WORD_W-1:0];
                    2'd2: stk_wd = {{(WORD_W-PW){bp_reg[PW-1]}}, bp_reg};
                    default: stk_wd = WORD_W'(npc_reg);
                endcase
                if (ccnt_reg == 2'd3) begin
                    bp_next  = sp_reg - PW'(1);
                    npc_next = target;
                    if (!wok_reg) stat_next = ST_RANGE;
                end
            end
            ACT_RTN0: begin
                stk_ra = rtn_a0[SW-1:0];
                if (!in_stk(rtn_a0)) stat_next = ST_RANGE;
            end
            ACT_RTN1: begin
                stk_ra = rtn_a1[SW-1:0];
                if (!in_stk(rtn_a1)) stat_next = ST_RANGE;
            end
            ACT_RTN2: begin
                npc_next = in_stk(rtn_a1) ? stk_q[CODE_AW-1:0] : '0;
                sp_next  = bp_reg + PW'(1);
                if (!nb_reg[WORD_W-1] && nb_reg < WORD_W'(STACK_DEPTH)) begin
                    bp_next = PW'(nb_reg[SW-1:0]);
                end else begin
                    bp_next = '0; stat_next = ST_RANGE;
                end
            end
            ACT_DIV_START: begin
                if (b_reg == '0) begin
                    rf_we = 1'b1; stat_next = ST_DIVZ;
                end
                rem_next = '0;
                quo_next = a_reg[WORD_W-1] ? '0 - a_reg : a_reg;
            end
            ACT_DIV_STEP: begin
                if (rem_sh >= {1'b0, dvs_reg}) begin
                    rem_next = rem_sh - {1'b0, dvs_reg};
                    quo_next = {quo_reg[WORD_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[WORD_W-2:0], 1'b0};
                end
            end
            ACT_DIV_DONE: begin
                rf_we = 1'b1;
                if (op_reg == OP_DIV) rf_wd = qneg_reg ? '0 - quo_reg : quo_reg;
                else rf_wd = rneg_reg ? '0 - rem_reg[WORD_W-1:0] : rem_reg[WORD_W-1:0];
            end
            ACT_OUT: ;
            default: ;
        endcase
    end

    // Memories: one write and one registered read each
    always_ff @(posedge aclk) begin
        if (rf_we) rf_mem[rf_wa] <= rf_wd;
        rf_q <= rf_mem[rf_ra];
        if (stk_we) stk_mem[stk_wa] <= stk_wd;
        stk_q <= stk_mem[stk_ra];
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= in_opcode; r_reg <= in_reg_r; l_reg <= in_level_l;
            m_reg <= in_operand_m; con_reg <= in_console_in;
        end
        if (cmd.act == ACT_RD_B) a_reg <= rf_q;
        if (cmd.act == ACT_RD_R) b_reg <= rf_q;
        if (cmd.act == ACT_CAP_R) rr_reg <= rf_q;
        if (cmd.act == ACT_RTN1) nb_reg <= in_stk(rtn_a0) ? stk_q : '0;
        if (cmd.act == ACT_DIV_START) begin
            dvs_reg  <= b_reg[WORD_W-1] ? '0 - b_reg : b_reg;
            qneg_reg <= a_reg[WORD_W-1] ^ b_reg[WORD_W-1];
            rneg_reg <= a_reg[WORD_W-1];
        end
        dcnt_reg <= (cmd.act == ACT_DIV_STEP) ? dcnt_reg - 5'd1 : 5'd31;
        ccnt_reg <= (cmd.act == ACT_CAL_WR) ? ccnt_reg + 2'd1 : 2'd0;
        npc_reg <= npc_next; stat_reg <= stat_next;
        pv_reg <= pv_next; pval_reg <= pval_next; tk_reg <= tk_next;
        wb_reg <= wb_next; wcnt_reg <= wcnt_next; wok_reg <= wok_next;
        rem_reg <= rem_next; quo_reg <= quo_next;
        if (cmd.out_load) begin
            o_next_pc <= npc_reg; o_halted <= halt_reg; o_status <= stat_reg;
            o_print_valid <= pv_reg; o_print_value <= pval_reg;
            o_input_taken <= tk_reg;
        end
    end

    // Machine pointers and clear counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= '0; bp_reg <= '0; sp_reg <= PW'(STACK_DEPTH);
            gp_reg <= '1; halt_reg <= 1'b0; clr_reg <= '0;
        end else begin
            bp_reg <= bp_next; sp_reg <= sp_next; gp_reg <= gp_next;
            halt_reg <= halt_next;
            if (cmd.out_load) pc_reg <= npc_reg;
            if (cmd.act == ACT_CLEAR) clr_reg <= clr_reg + SW'(1);
        end
    end

endmodule

[design/pl0rsm_control.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl0rsm_control
// Instruction sequencer: clear pass, operand fetch, link walk, divide, result.
// ----------------------------------------------------------------------------
module pl0rsm_control
    import pl0rsm_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    output logic  m_valid,
    input  logic  m_ready,
    input  stat_t st,
    output cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RD_A, S_RD_B, S_RD_R, S_CAP_R, S_EXEC, S_WALK_INIT,
        S_WALK_STEP, S_WALK_CAP, S_MEM, S_MEM_DONE, S_CAL_WR, S_RTN0, S_RTN1,
        S_RTN2, S_DIV_START, S_DIV_STEP, S_DIV_DONE, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, slot_free;

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;

    // Map state to datapath command
    always_comb begin
        unique case (state_reg)
            S_CLEAR:     cmd.act = ACT_CLEAR;
            S_IDLE:      cmd.act = ACT_IDLE;
            S_RD_A:      cmd.act = ACT_RD_A;
            S_RD_B:      cmd.act = ACT_RD_B;
            S_RD_R:      cmd.act = ACT_RD_R;
            S_CAP_R:     cmd.act = ACT_CAP_R;
            S_EXEC:      cmd.act = ACT_EXEC;
            S_WALK_INIT: cmd.act = ACT_WALK_INIT;
            S_WALK_STEP: cmd.act = ACT_WALK_STEP;
            S_WALK_CAP:  cmd.act = ACT_WALK_CAP;
            S_MEM:       cmd.act = ACT_MEM;
            S_MEM_DONE:  cmd.act = ACT_MEM_DONE;
            S_CAL_WR:    cmd.act = ACT_CAL_WR;
            S_RTN0:      cmd.act = ACT_RTN0;
            S_RTN1:      cmd.act = ACT_RTN1;
            S_RTN2:      cmd.act = ACT_RTN2;
            S_DIV_START: cmd.act = ACT_DIV_START;
            S_DIV_STEP:  cmd.act = ACT_DIV_STEP;
            S_DIV_DONE:  cmd.act = ACT_DIV_DONE;
            default:     cmd.act = ACT_OUT;
        endcase
        cmd.load     = (state_reg == S_IDLE) && s_valid;
        cmd.out_load = (state_reg == S_OUT) && slot_free;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:     if (st.clear_done) state_next = S_IDLE;
            S_IDLE:      if (s_valid) state_next = st.halt ? S_OUT : S_RD_A;
            S_RD_A:      state_next = S_RD_B;
            S_RD_B:      state_next = S_RD_R;
            S_RD_R:      state_next = S_CAP_R;
            S_CAP_R:     state_next = S_EXEC;
            S_EXEC: begin
                case (st.op)
                    OP_LOD, OP_STO:   state_next = S_WALK_INIT;
                    OP_CAL:           state_next = st.cal_ovf ? S_OUT : S_WALK_INIT;
                    OP_RTN:           state_next = S_RTN0;
                    OP_DIV, OP_MOD:   state_next = S_DIV_START;
                    default:          state_next = S_OUT;
                endcase
            end
            S_WALK_INIT: state_next = S_WALK_STEP;
            S_WALK_STEP: begin
                if (st.walk_idle) state_next = (st.op == OP_CAL) ? S_CAL_WR : S_MEM;
                else if (!st.walk_bad) state_next = S_WALK_CAP;
            end
            S_WALK_CAP:  state_next = S_WALK_STEP;
            S_MEM:       state_next = (st.op == OP_LOD && st.mem_ok) ? S_MEM_DONE : S_OUT;
            S_MEM_DONE:  state_next = S_OUT;
            S_CAL_WR:    if (st.cal_last) state_next = S_OUT;
            S_RTN0:      state_next = S_RTN1;
            S_RTN1:      state_next = S_RTN2;
            S_RTN2:      state_next = S_OUT;
            S_DIV_START: state_next = st.div_zero ? S_OUT : S_DIV_STEP;
            S_DIV_STEP:  if (st.div_last) state_next = S_DIV_DONE;
            S_DIV_DONE:  state_next = S_OUT;
            default:     if (slot_free) state_next = S_IDLE;
        endcase
    end

    // Hold state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("second transfer during work");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready)) else $error("result overwritten");
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLEAR |-> !s_ready && !m_valid_reg) else $error("busy in clear");

endmodule

[design/pl0_register_stack_machine_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl0_register_stack_machine_unit
// PL/0 register machine executing one instruction per input transfer.
// ----------------------------------------------------------------------------
// Usage: feed the instruction found at m_next_pc on the s_ channel
// (s_opcode, s_reg_r, s_level_l, s_operand_m, s_console_in); each accepted
// instruction gives exactly one result transfer on the m_ channel with the
// next PC, halt flag, status and any console print or read.
// Sequence: plain operations read their operands and execute; divide or
// modulo by zero stops at the divider start; return reads the saved base
// and return address; store, load and call first walk the static links,
// one step per level and one more when the walk leaves the stack (a load
// that misses the stack then skips its read-back), and call then writes
// its frame. Divide and modulo run a 32-step restoring divider, which sets
// the worst case. A halted machine answers straight from idle. One instruction
// is in flight at a time; the next is accepted once the previous result has
// been registered. Reset: after aresetn is released the block sweeps the
// data stack and the register file, one word a cycle, before s_ready rises.
// A stalled receiver holds the result register, and the block then waits
// with the next instruction's result until the register is free.
// ----------------------------------------------------------------------------
module pl0_register_stack_machine_unit
    import pl0rsm_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [4:0]                s_opcode,
    input  logic [2:0]                s_reg_r,
    input  logic [2:0]                s_level_l,
    input  logic signed [15:0]        s_operand_m,
    input  logic signed [WORD_W-1:0]  s_console_in,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [CODE_AW-1:0]        m_next_pc,
    output logic                      m_halted,
    output logic [1:0]                m_status,
    output logic                      m_print_valid,
    output logic signed [WORD_W-1:0]  m_print_value,
    output logic                      m_input_taken
);

    cmd_t  cmd;
    stat_t st;

    pl0rsm_control u_control (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    pl0rsm_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .st            (st),
        .in_opcode     (s_opcode),
        .in_reg_r      (s_reg_r),
        .in_level_l    (s_level_l),
        .in_operand_m  (s_operand_m),
        .in_console_in (s_console_in),
        .o_next_pc     (m_next_pc),
        .o_halted      (m_halted),
        .o_status      (m_status),
        .o_print_valid (m_print_valid),
        .o_print_value (m_print_value),
        .o_input_taken (m_input_taken)
    );

endmodule
